// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/smf_pkg.sv =====
package smf_pkg;

  localparam int unsigned MaxRows    = 4096;
  localparam int unsigned MaxCols    = 4096;
  localparam int unsigned MaxFactors = 16;
  localparam int unsigned RowW       = $clog2(MaxRows);
  localparam int unsigned ColW       = $clog2(MaxCols);
  localparam int unsigned FacW       = $clog2(MaxFactors);

  localparam logic [2:0] KindTrain = 3'd0;
  localparam logic [2:0] KindEval  = 3'd1;
  localparam logic [2:0] KindWrRow = 3'd2;
  localparam logic [2:0] KindWrCol = 3'd3;
  localparam logic [2:0] KindRdRow = 3'd4;
  localparam logic [2:0] KindRdCol = 3'd5;
  localparam logic [2:0] KindClear = 3'd6;

  localparam logic [2:0] CfgFactorCount = 3'd0;
  localparam logic [2:0] CfgLearnRate   = 3'd1;
  localparam logic [2:0] CfgBiasReg     = 3'd2;
  localparam logic [2:0] CfgFactorReg   = 3'd3;
  localparam logic [2:0] CfgGlobalMean  = 3'd4;

  localparam logic [62:0] AccMax = {63{1'b1}};

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone,
    OpLatch,     // capture item, issue bias reads
    OpBiasLoad,  // bias read data arrives, start residual
    OpFacRead,   // read factor k of both vectors
    OpDotMul,    // product of factor pair
    OpDotAcc,    // subtract rounded product
    OpResid,     // saturate residual
    OpBiasGrad,  // bias gradients
    OpBiasStep,  // lr multiply for biases
    OpBiasWr,    // write biases
    OpFacGrad,   // factor gradients
    OpFacStep,   // lr multiply for factors
    OpFacWr,     // write factors
    OpEvalSq,    // square residual
    OpEvalAcc,   // update sums
    OpMisc       // write, read, clear
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [FacW-1:0]  k;
  } dp_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // round Q.48 to Q.24, floor after adding half
  function automatic logic signed [65:0] round24(input logic signed [65:0] x);
    logic signed [65:0] t;
    t = x + 66'sd8388608;
    return t >>> 24;
  endfunction

endpackage

// ===== src/smf_datapath.sv =====
module smf_datapath import smf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  logic [2:0]        kind_i,
  input  logic [11:0]       row_index_i,
  input  logic [11:0]       col_index_i,
  input  logic signed [31:0] rating_i,
  input  logic [4:0]        slot_i,
  input  logic signed [31:0] write_value_i,
  input  logic [23:0]       learning_rate_i,
  input  logic [23:0]       bias_reg_i,
  input  logic [23:0]       factor_reg_i,
  input  logic signed [31:0] global_mean_i,
  output logic signed [31:0] residual_o,
  output logic signed [31:0] read_value_o,
  output logic [62:0]       abs_error_sum_o,
  output logic [62:0]       sq_error_sum_o
);

  logic signed [31:0] row_bias_mem [MaxRows];
  logic signed [31:0] col_bias_mem [MaxCols];
  logic signed [31:0] row_fac_mem  [MaxRows*MaxFactors];
  logic signed [31:0] col_fac_mem  [MaxCols*MaxFactors];

  logic [2:0]         kind_q;
  logic [RowW-1:0]    row_q;
  logic [ColW-1:0]    col_q;
  logic signed [31:0] rating_q;
  logic [4:0]         slot_q;
  logic signed [31:0] wval_q;

  logic signed [31:0] rb_rd_q, cb_rd_q, u_rd_q, v_rd_q;
  logic signed [31:0] rb_q, cb_q;
  logic signed [65:0] acc_q;
  logic signed [63:0] prod_a_q;
  logic signed [31:0] resid_q, rdval_q;
  logic signed [31:0] grad_a_q, grad_b_q;
  logic signed [55:0] step_a_q, step_b_q;
  logic [62:0]        abs_q, sq_q;
  logic [63:0]        sqp_q;

  logic               is_row, slot_ok;
  logic [RowW+FacW-1:0] ur_addr, uw_addr;
  logic [ColW+FacW-1:0] vr_addr, vw_addr;
  logic [FacW-1:0]    slot_k, slot_in_k, k_rd;

  assign is_row  = (kind_q == KindWrRow) || (kind_q == KindRdRow);
  assign slot_ok = slot_q <= 5'(MaxFactors);
  assign slot_k  = FacW'(slot_q - 5'd1);
  assign slot_in_k = FacW'(slot_i - 5'd1);
  // a factor write fetches the next factor so its data is ready for that factor's gradient state
  assign k_rd    = (cmd_i.op == OpFacWr) ? cmd_i.k + FacW'(1) : cmd_i.k;
  assign ur_addr = (cmd_i.op == OpLatch) ? {row_index_i, slot_in_k} : {row_q, k_rd};
  assign vr_addr = (cmd_i.op == OpLatch) ? {col_index_i, slot_in_k} : {col_q, k_rd};
  assign uw_addr = {row_q, cmd_i.k};
  assign vw_addr = {col_q, cmd_i.k};

  // memory reads: words of the item at entry, then factor k of the held item
  always_ff @(posedge clk_i) begin
    rb_rd_q <= row_bias_mem[row_index_i];
    cb_rd_q <= col_bias_mem[col_index_i];
    u_rd_q  <= row_fac_mem[ur_addr];
    v_rd_q  <= col_fac_mem[vr_addr];
  end

  logic signed [31:0] rb_new, cb_new, u_new, v_new;
  assign rb_new = sat32(66'(rb_q) + round24(66'(step_a_q)));
  assign cb_new = sat32(66'(cb_q) + round24(66'(step_b_q)));
  assign u_new  = sat32(66'(u_rd_q) + round24(66'(step_a_q)));
  assign v_new  = sat32(66'(v_rd_q) + round24(66'(step_b_q)));

  // memory writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OpBiasWr) begin
      row_bias_mem[row_q] <= rb_new;
      col_bias_mem[col_q] <= cb_new;
    end
    if (cmd_i.op == OpFacWr) begin
      row_fac_mem[uw_addr] <= u_new;
      col_fac_mem[vw_addr] <= v_new;
    end
    if (cmd_i.op == OpMisc && slot_ok) begin
      if (kind_q == KindWrRow) begin
        if (slot_q == 5'd0) row_bias_mem[row_q] <= wval_q;
        else row_fac_mem[{row_q, slot_k}] <= wval_q;
      end
      if (kind_q == KindWrCol) begin
        if (slot_q == 5'd0) col_bias_mem[col_q] <= wval_q;
        else col_fac_mem[{col_q, slot_k}] <= wval_q;
      end
    end
  end

  logic signed [31:0] misc_rd;
  always_comb begin
    misc_rd = '0;
    if (slot_ok && (kind_q == KindRdRow || kind_q == KindRdCol)) begin
      if (slot_q == 5'd0) misc_rd = is_row ? rb_rd_q : cb_rd_q;
      else misc_rd = is_row ? u_rd_q : v_rd_q;
    end
  end

  logic signed [65:0] sq_round;
  logic [63:0]        abs_sum, sq_sum;
  assign sq_round = round24($signed({2'b00, sqp_q}));
  assign abs_sum  = 64'(abs_q) + 64'(resid_q[31] ? -66'(resid_q) : 66'(resid_q));
  assign sq_sum   = 64'(sq_q) + sq_round[63:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_q <= '0;
      sq_q  <= '0;
    end else if (cmd_i.op == OpEvalAcc) begin
      abs_q <= abs_sum[63] ? AccMax : abs_sum[62:0];
      sq_q  <= sq_sum[63] ? AccMax : sq_sum[62:0];
    end else if (cmd_i.op == OpMisc && kind_q == KindClear) begin
      abs_q <= '0;
      sq_q  <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OpLatch: begin
        kind_q   <= kind_i;
        row_q    <= row_index_i;
        col_q    <= col_index_i;
        rating_q <= rating_i;
        slot_q   <= slot_i;
        wval_q   <= write_value_i;
        resid_q  <= '0;
        rdval_q  <= '0;
      end
      OpBiasLoad: begin
        rb_q  <= rb_rd_q;
        cb_q  <= cb_rd_q;
        acc_q <= 66'(rating_q) - 66'(global_mean_i) - 66'(rb_rd_q) - 66'(cb_rd_q);
      end
      OpDotMul: prod_a_q <= 64'(u_rd_q) * 64'(v_rd_q);
      OpDotAcc: acc_q <= acc_q - round24(66'(prod_a_q));
      OpResid:  resid_q <= sat32(acc_q);
      OpBiasGrad: begin
        grad_a_q <= sat32(66'(resid_q) - round24(66'(rb_q) * 66'($signed({1'b0, bias_reg_i}))));
        grad_b_q <= sat32(66'(resid_q) - round24(66'(cb_q) * 66'($signed({1'b0, bias_reg_i}))));
      end
      OpFacRead: ;
      OpFacGrad: begin
        grad_a_q <= sat32(round24(66'(resid_q) * 66'(v_rd_q)
                    - 66'(u_rd_q) * 66'($signed({1'b0, factor_reg_i}))));
        grad_b_q <= sat32(round24(66'(resid_q) * 66'(u_rd_q)
                    - 66'(v_rd_q) * 66'($signed({1'b0, factor_reg_i}))));
      end
      OpBiasStep, OpFacStep: begin
        step_a_q <= 56'(grad_a_q) * 56'($signed({1'b0, learning_rate_i}));
        step_b_q <= 56'(grad_b_q) * 56'($signed({1'b0, learning_rate_i}));
      end
      OpEvalSq: sqp_q <= 64'(64'(resid_q) * 64'(resid_q));
      OpMisc:   rdval_q <= misc_rd;
      default: ;
    endcase
  end

  assign residual_o      = resid_q;
  assign read_value_o    = rdval_q;
  assign abs_error_sum_o = abs_q;
  assign sq_error_sum_o  = sq_q;

endmodule

// ===== src/smf_ctrl.sv =====
module smf_ctrl import smf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] kind_i,
  input  logic [4:0] nf_i,
  output logic       out_valid,
  input  logic       out_stall,
  output dp_cmd_t    cmd_o
);

  localparam logic [3:0] SIdle = 4'd0, SBias = 4'd1, SFRd = 4'd2, SFMul = 4'd3,
    SFAcc = 4'd4, SRes = 4'd5, SBGrad = 4'd6, SBStep = 4'd7, SBWr = 4'd8,
    SUGrd = 4'd9, SUStep = 4'd10, SUWr = 4'd11, SSq = 4'd12, SAcc = 4'd13,
    SMisc = 4'd14, SOut = 4'd15;

  logic [3:0]      st_q, st_d;
  logic [FacW:0]   k_q, k_d;
  logic [2:0]      kind_q, kind_d;
  logic            train;

  assign train    = kind_q == KindTrain;
  assign in_stall = (st_q != SIdle);
  assign out_valid = (st_q == SOut);

  always_comb begin
    st_d = st_q; k_d = k_q; kind_d = kind_q;
    cmd_o.op = OpNone;
    cmd_o.k  = k_q[FacW-1:0];
    unique case (st_q)
      SIdle: if (in_valid) begin
        cmd_o.op = OpLatch; kind_d = kind_i; k_d = '0;
        st_d = (kind_i == KindTrain || kind_i == KindEval) ? SBias : SMisc;
      end
      SBias: begin
        cmd_o.op = OpBiasLoad;
        st_d = (nf_i == 5'd0) ? SRes : SFRd;
      end
      SFRd: begin cmd_o.op = OpFacRead; st_d = SFMul; end
      SFMul: begin cmd_o.op = OpDotMul; st_d = SFAcc; end
      SFAcc: begin
        cmd_o.op = OpDotAcc; k_d = k_q + 1'b1;
        st_d = ((FacW+1)'(nf_i) <= k_q + 1'b1) ? SRes : SFRd;
      end
      SRes: begin cmd_o.op = OpResid; k_d = '0; st_d = train ? SBGrad : SSq; end
      SBGrad: begin cmd_o.op = OpBiasGrad; st_d = SBStep; end
      SBStep: begin cmd_o.op = OpBiasStep; st_d = SBWr; end
      SBWr: begin
        cmd_o.op = OpBiasWr;
        st_d = (nf_i == 5'd0) ? SOut : SUGrd;
      end
      SUGrd: begin cmd_o.op = OpFacGrad; st_d = SUStep; end
      SUStep: begin cmd_o.op = OpFacStep; st_d = SUWr; end
      SUWr: begin
        cmd_o.op = OpFacWr; k_d = k_q + 1'b1;
        st_d = ((FacW+1)'(nf_i) <= k_q + 1'b1) ? SOut : SUGrd;
      end
      SSq: begin cmd_o.op = OpEvalSq; st_d = SAcc; end
      SAcc: begin cmd_o.op = OpEvalAcc; st_d = SOut; end
      SMisc: begin cmd_o.op = OpMisc; st_d = SOut; end
      SOut: if (!out_stall) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; k_q <= '0; kind_q <= '0;
    end else begin
      st_q <= st_d; k_q <= k_d; kind_q <= kind_d;
    end
  end

endmodule

// ===== src/sgd_matrix_factor_update.sv =====
// sequential engine: one item at a time (in_stall until its result is taken), controller plus datapath
// steps, accept through result: misc kinds latch then misc op; evaluate latches, loads
//   biases, reads/multiplies/accumulates per factor, saturates the residual, squares it and
//   updates the sums; train does the same up to the residual, then bias gradient, step and
//   write, then factor gradient, step and write per factor in use
// reset: controller idle, error sums zero, config registers at defaults; stores undefined
module sgd_matrix_factor_update import smf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         kind_i,
  input  logic [11:0]        row_index_i,
  input  logic [11:0]        col_index_i,
  input  logic signed [31:0] rating_i,
  input  logic [4:0]         slot_i,
  input  logic signed [31:0] write_value_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] residual_o,
  output logic signed [31:0] read_value_o,
  output logic [62:0]        abs_error_sum_o,
  output logic [62:0]        sq_error_sum_o
);

  logic [4:0]         nf_q;
  logic [23:0]        lr_q, breg_q, freg_q;
  logic signed [31:0] gm_q;
  logic [4:0]         nf_eff;
  dp_cmd_t            cmd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_q <= 5'd8; lr_q <= 24'd16777; breg_q <= 24'd167772;
      freg_q <= 24'd167772; gm_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgFactorCount: nf_q <= cfg_data_i[4:0];
        CfgLearnRate:   lr_q <= cfg_data_i[23:0];
        CfgBiasReg:     breg_q <= cfg_data_i[23:0];
        CfgFactorReg:   freg_q <= cfg_data_i[23:0];
        CfgGlobalMean:  gm_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp factor count to the store depth
  assign nf_eff = (nf_q > 5'(MaxFactors)) ? 5'(MaxFactors) : nf_q;

  smf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .kind_i, .nf_i(nf_eff),
    .out_valid, .out_stall, .cmd_o(cmd)
  );

  smf_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .kind_i, .row_index_i, .col_index_i, .rating_i,
    .slot_i, .write_value_i, .learning_rate_i(lr_q), .bias_reg_i(breg_q),
    .factor_reg_i(freg_q), .global_mean_i(gm_q), .residual_o, .read_value_o,
    .abs_error_sum_o, .sq_error_sum_o
  );

endmodule

// ===== src/smf_checker.sv =====
`include "assert_macros.svh"
module smf_props (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [62:0] abs_error_sum_o
);
  // no new item while a result waits
  `ASSERT_IMPL(a_busy_out, clk_i, rst_ni, out_valid, in_stall)
  // a result holds until taken
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && out_stall, out_valid)
  // sums stay put while idle
  `ASSERT_NEXT(a_sum_idle, clk_i, rst_ni, !in_stall && !in_valid, $stable(abs_error_sum_o))
endmodule

bind sgd_matrix_factor_update smf_props u_chk (.*);
